[hdl/mbsh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsh_pkg
// Shared types and constants for the MurmurHash2 byte-stream hash core.
// ----------------------------------------------------------------------------
package mbsh_pkg;

  // Mixing multiplier and shift amounts
  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int unsigned WORD_SHIFT  = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MK1,
    ST_MK2,
    ST_MH,
    ST_MACC,
    ST_TAIL,
    ST_FIN1,
    ST_FIN2
  } state_t;

  // Multiplier operand select
  typedef enum logic [2:0] {
    MS_K,
    MS_K24,
    MS_ACC,
    MS_TAIL,
    MS_FIN
  } mul_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic     accept;
    mul_sel_t mul_sel;
    logic     prod_load;
    logic     k_load;
    logic     acc_mix;
    logic     tail_step;
    logic     out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic word_full;
    logic out_free;
  } sts_t;

endpackage

[hdl/murmur_byte_stream_hash_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur_byte_stream_hash_core
// 32-bit MurmurHash2 over a byte stream, one byte per input word.
//
//   Channel  Direction  Handshake           Payload
//   in       input      in_valid/in_stall   data_byte, byte_valid, first_item,
//                                           last_item, message_length
//   out      output     out_valid/out_stall hash_value
//   cfg      input      cfg_wr_en           cfg_wr_data (hash seed)
//
// A word without a completed 32-bit group is only gathered; a word that
// completes a group steps MK1, MK2, MH, MACC: three passes through the one
// shared multiplier, then a last word adds the tail and finalization steps.
// Reset (synchronous, active low) clears seed, hash state and result valid.
// A result waiting on out_stall holds the sequencer in its final step.
// ----------------------------------------------------------------------------
module murmur_byte_stream_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_first_item,
  input  logic        in_last_item,
  input  logic [31:0] in_message_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value
);

  mbsh_pkg::cmd_t cmd;
  mbsh_pkg::sts_t sts;

  // Sequencer
  mbsh_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_item (in_last_item),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Hash datapath
  mbsh_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_data_byte      (in_data_byte),
    .in_byte_valid     (in_byte_valid),
    .in_first_item     (in_first_item),
    .in_message_length (in_message_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hash_value    (out_hash_value),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

[hdl/mbsh_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsh_ctrl
// Sequencer: accepts one word at a time and steps the shared multiplier
// through word mixing, tail and finalization.
// ----------------------------------------------------------------------------
module mbsh_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last_item,
  output logic           in_stall,
  input  mbsh_pkg::sts_t sts,
  output mbsh_pkg::cmd_t cmd
);

  mbsh_pkg::state_t state_r, state_nxt;
  logic             last_r, last_nxt;

  // State and pending-last registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbsh_pkg::ST_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    in_stall      = 1'b1;
    cmd.accept    = 1'b0;
    cmd.mul_sel   = mbsh_pkg::MS_K;
    cmd.prod_load = 1'b0;
    cmd.k_load    = 1'b0;
    cmd.acc_mix   = 1'b0;
    cmd.tail_step = 1'b0;
    cmd.out_load  = 1'b0;
    unique case (state_r)
      mbsh_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          last_nxt   = in_last_item;
          if (sts.word_full) begin
            state_nxt = mbsh_pkg::ST_MK1;
          end else if (in_last_item) begin
            state_nxt = mbsh_pkg::ST_TAIL;
          end
        end
      end
      mbsh_pkg::ST_MK1: begin
        cmd.mul_sel   = mbsh_pkg::MS_K;
        cmd.prod_load = 1'b1;
        state_nxt     = mbsh_pkg::ST_MK2;
      end
      mbsh_pkg::ST_MK2: begin
        cmd.mul_sel   = mbsh_pkg::MS_K24;
        cmd.prod_load = 1'b1;
        state_nxt     = mbsh_pkg::ST_MH;
      end
      mbsh_pkg::ST_MH: begin
        cmd.k_load    = 1'b1;
        cmd.mul_sel   = mbsh_pkg::MS_ACC;
        cmd.prod_load = 1'b1;
        state_nxt     = mbsh_pkg::ST_MACC;
      end
      mbsh_pkg::ST_MACC: begin
        cmd.acc_mix = 1'b1;
        state_nxt   = last_r ? mbsh_pkg::ST_TAIL : mbsh_pkg::ST_IDLE;
      end
      mbsh_pkg::ST_TAIL: begin
        cmd.mul_sel   = mbsh_pkg::MS_TAIL;
        cmd.tail_step = 1'b1;
        state_nxt     = mbsh_pkg::ST_FIN1;
      end
      mbsh_pkg::ST_FIN1: begin
        cmd.mul_sel   = mbsh_pkg::MS_FIN;
        cmd.prod_load = 1'b1;
        state_nxt     = mbsh_pkg::ST_FIN2;
      end
      mbsh_pkg::ST_FIN2: begin
        // hold until the result register is free
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          last_nxt     = 1'b0;
          state_nxt    = mbsh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mbsh_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/mbsh_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsh_dp
// Datapath: seed register, byte gathering, running hash, one shared
// multiplier by the mixing constant, and the result register.
// ----------------------------------------------------------------------------
module mbsh_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic [31:0]    cfg_wr_data,
  input  logic [7:0]     in_data_byte,
  input  logic           in_byte_valid,
  input  logic           in_first_item,
  input  logic [31:0]    in_message_length,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [31:0]    out_hash_value,
  input  mbsh_pkg::cmd_t cmd,
  output mbsh_pkg::sts_t sts
);

  logic [31:0] seed_r;
  logic [31:0] acc_r, acc_nxt;
  logic [23:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] k_r, k_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;

  logic [31:0] acc_eff;
  logic [23:0] pend_eff;
  logic [1:0]  cnt_eff;
  logic [31:0] mul_a;
  logic [31:0] mul_out;

  // Start of message resets the running state
  assign acc_eff  = in_first_item ? (seed_r ^ in_message_length) : acc_r;
  assign pend_eff = in_first_item ? 24'd0 : pend_r;
  assign cnt_eff  = in_first_item ? 2'd0  : cnt_r;

  assign sts.word_full = in_byte_valid && (cnt_eff == 2'd3);
  assign sts.out_free  = !out_valid_r || !out_stall;

  // Shared multiplier operand
  always_comb begin
    case (cmd.mul_sel)
      mbsh_pkg::MS_K:    mul_a = k_r;
      mbsh_pkg::MS_K24:  mul_a = prod_r ^ (prod_r >> mbsh_pkg::WORD_SHIFT);
      mbsh_pkg::MS_ACC:  mul_a = acc_r;
      mbsh_pkg::MS_TAIL: mul_a = acc_r ^ {8'd0, pend_r};
      mbsh_pkg::MS_FIN:  mul_a = prod_r ^ (prod_r >> mbsh_pkg::FIN_SHIFT_A);
      default:           mul_a = k_r;
    endcase
  end

  assign mul_out = mul_a * mbsh_pkg::MIX_MUL;

  // Next values of the datapath registers
  always_comb begin
    acc_nxt       = acc_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r;
    out_hash_nxt  = out_hash_r;

    // drop the result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // accept: load start value, gather byte or latch a full word
    if (cmd.accept) begin
      acc_nxt  = acc_eff;
      pend_nxt = pend_eff;
      cnt_nxt  = cnt_eff;
      if (in_byte_valid) begin
        if (cnt_eff == 2'd3) begin
          k_nxt    = {in_data_byte, pend_eff};
          pend_nxt = 24'd0;
          cnt_nxt  = 2'd0;
        end else begin
          case (cnt_eff)
            2'd0:    pend_nxt = {pend_eff[23:8], in_data_byte};
            2'd1:    pend_nxt = {pend_eff[23:16], in_data_byte, pend_eff[7:0]};
            default: pend_nxt = {in_data_byte, pend_eff[15:0]};
          endcase
          cnt_nxt = cnt_eff + 2'd1;
        end
      end
    end

    if (cmd.prod_load) begin
      prod_nxt = mul_out;
    end

    // hold mixed word while the accumulator is multiplied
    if (cmd.k_load) begin
      k_nxt = prod_r;
    end

    if (cmd.acc_mix) begin
      acc_nxt = prod_r ^ k_r;
    end

    // tail fold, then clear gathered bytes
    if (cmd.tail_step) begin
      prod_nxt = (cnt_r != 2'd0) ? mul_out : acc_r;
      pend_nxt = 24'd0;
      cnt_nxt  = 2'd0;
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_hash_nxt  = prod_r ^ (prod_r >> mbsh_pkg::FIN_SHIFT_B);
    end
  end

  // Control and hash state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= 32'd0;
      acc_r       <= 32'd0;
      pend_r      <= 24'd0;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      acc_r       <= acc_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Work and result payload
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    prod_r     <= prod_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule
